@@ design/ttce_pkg.sv @@
// ----------------------------------------------------------------------------
// ttce_pkg
// Shared types, codes and limits of the text terminal cursor engine.
// ----------------------------------------------------------------------------
package ttce_pkg;

   localparam int MAX_COLS = 128;
   localparam int MAX_ROWS = 64;

   localparam int COL_HARD = (MAX_COLS < 128) ? MAX_COLS : 128;
   localparam int ROW_HARD = (MAX_ROWS < 64) ? MAX_ROWS : 64;

   localparam logic [7:0] COL_LIM = 8'(COL_HARD);
   localparam logic [6:0] ROW_LIM = 7'(ROW_HARD);

   localparam logic [7:0] COL_COUNT_RST = 8'd80;
   localparam logic [6:0] ROW_COUNT_RST = 7'd37;

   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_FF    = 8'd12;
   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_NUL   = 8'd0;

   localparam logic FUNC_TYPE = 1'b0;
   localparam logic FUNC_MOVE = 1'b1;

   localparam logic REG_COL_COUNT = 1'b0;
   localparam logic REG_ROW_COUNT = 1'b1;

   typedef enum logic [1:0] {
      ACT_CELL  = 2'd0,
      ACT_SPAN  = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      KIND_MOVE,
      KIND_EOL,
      KIND_CLEAR,
      KIND_BS,
      KIND_PRINT
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] ch;
      logic [7:0] fore;
      logic [7:0] back;
      logic [6:0] col;
      logic [5:0] row;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic [6:0] cell_col;
      logic [5:0] cell_row;
      logic [7:0] glyph;
      logic [7:0] fore_color;
      logic [7:0] back_color;
      logic [6:0] cursor_col_now;
      logic [5:0] cursor_row_now;
   } res_type;

   typedef struct packed {
      logic [7:0] cols;
      logic [6:0] rows;
   } geom_type;

   function automatic logic [7:0] limit_cols(input logic [7:0] v);
      logic [7:0] t;
      t = (v == 8'd0) ? 8'd1 : v;
      return (t > COL_LIM) ? COL_LIM : t;
   endfunction

   function automatic logic [6:0] limit_rows(input logic [6:0] v);
      logic [6:0] t;
      t = (v == 7'd0) ? 7'd1 : v;
      return (t > ROW_LIM) ? ROW_LIM : t;
   endfunction

endpackage

@@ design/ttce_fifo.sv @@
// ----------------------------------------------------------------------------
// ttce_fifo
// Two-entry queue with registered full/empty, used between the stages.
// ----------------------------------------------------------------------------
module ttce_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_wr   = wr_en & ~full;
   assign do_rd   = rd_en & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 2'd1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ design/ttce_front.sv @@
// ----------------------------------------------------------------------------
// ttce_front
// Decodes an incoming item into a command kind for the back end.
// ----------------------------------------------------------------------------
module ttce_front
   import ttce_pkg::*;
(
   input  logic       func,
   input  logic [7:0] ch,
   input  logic [7:0] fore,
   input  logic [7:0] back,
   input  logic [6:0] col,
   input  logic [5:0] row,
   output cmd_type    cmd
);

   kind_type kind;

   always_comb begin
      if (func == FUNC_MOVE) begin
         kind = KIND_MOVE;
      end else if (ch == CH_CR || ch == CH_LF) begin
         kind = KIND_EOL;
      end else if (ch == CH_FF) begin
         kind = KIND_CLEAR;
      end else if (ch == CH_BS) begin
         kind = KIND_BS;
      end else begin
         kind = KIND_PRINT;
      end
   end

   assign cmd = '{kind: kind, ch: ch, fore: fore, back: back, col: col, row: row};

endmodule

@@ design/ttce_back.sv @@
// ----------------------------------------------------------------------------
// ttce_back
// Holds the cursor and turns each decoded command into one result item.
// ----------------------------------------------------------------------------
module ttce_back
   import ttce_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  geom_type geom,
   input  logic     cmd_avail,
   input  cmd_type  cmd,
   output logic     cmd_take,
   input  logic     res_full,
   output logic     res_push,
   output res_type  res
);

   logic [6:0] cur_col_ff, cur_col_in;
   logic [5:0] cur_row_ff, cur_row_in;
   logic [6:0] col_fit, col_last, mv_col;
   logic [5:0] row_fit, row_last, mv_row;
   logic [7:0] col_inc;
   logic [6:0] row_inc;
   logic [5:0] row_next;
   logic       step;

   assign step     = cmd_avail & ~res_full;
   assign cmd_take = step;
   assign res_push = step;

   assign col_last = 7'(geom.cols - 8'd1);
   assign row_last = 6'(geom.rows - 7'd1);
   assign col_fit  = ({1'b0, cur_col_ff} >= geom.cols) ? col_last : cur_col_ff;
   assign row_fit  = ({1'b0, cur_row_ff} >= geom.rows) ? row_last : cur_row_ff;
   assign mv_col   = ({1'b0, cmd.col} >= geom.cols) ? col_last : cmd.col;
   assign mv_row   = ({1'b0, cmd.row} >= geom.rows) ? row_last : cmd.row;
   assign col_inc  = {1'b0, col_fit} + 8'd1;
   assign row_inc  = {1'b0, row_fit} + 7'd1;
   assign row_next = (row_inc >= geom.rows) ? 6'd0 : row_inc[5:0];

   always_comb begin
      res.action     = ACT_NONE;
      res.cell_col   = 7'd0;
      res.cell_row   = 6'd0;
      res.glyph      = CH_NUL;
      res.fore_color = cmd.fore;
      res.back_color = cmd.back;
      cur_col_in     = col_fit;
      cur_row_in     = row_fit;
      unique case (cmd.kind)
         KIND_MOVE: begin
            cur_col_in = mv_col;
            cur_row_in = mv_row;
         end
         KIND_EOL: begin
            res.action   = ACT_SPAN;
            res.cell_col = col_fit;
            res.cell_row = row_fit;
            res.glyph    = CH_SPACE;
            cur_col_in   = 7'd0;
            cur_row_in   = row_next;
         end
         KIND_CLEAR: begin
            res.action = ACT_CLEAR;
            res.glyph  = CH_SPACE;
            cur_col_in = 7'd0;
            cur_row_in = 6'd0;
         end
         KIND_BS: begin
            if (col_fit != 7'd0) begin
               res.action   = ACT_CELL;
               res.cell_col = col_fit - 7'd1;
               res.cell_row = row_fit;
               res.glyph    = CH_SPACE;
               cur_col_in   = col_fit - 7'd1;
            end
         end
         KIND_PRINT: begin
            res.action   = ACT_CELL;
            res.cell_col = col_fit;
            res.cell_row = row_fit;
            res.glyph    = cmd.ch;
            if (col_inc >= geom.cols) begin
               cur_col_in = 7'd0;
               cur_row_in = row_next;
            end else begin
               cur_col_in = col_inc[6:0];
            end
         end
         default: begin
            cur_col_in = col_fit;
            cur_row_in = row_fit;
         end
      endcase
      res.cursor_col_now = cur_col_in;
      res.cursor_row_now = cur_row_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff <= 7'd0;
         cur_row_ff <= 6'd0;
      end else if (step) begin
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
      end
   end

endmodule

@@ design/text_terminal_cursor_engine_unit.sv @@
// ----------------------------------------------------------------------------
// text_terminal_cursor_engine_unit
// Text-mode terminal cursor engine: one screen write or cursor move per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive req_* and raise push; the item is taken on an edge
//   where push is high and full is low. Result queue: while empty is low the
//   oldest result sits on rsp_*; pop on that edge consumes it.
//   Every item gives exactly one result, in order.
//   Config: csr_index 0 = column count, 1 = row count, written on an edge with
//   csr_valid high (csr_ready is always high). Write only while idle.
// Path: each item passes through the command queue, then its result through the result queue.
// Throughput: one item per cycle unless stalled; the back end's cursor update
//   is a combinational compare/increment/clamp, so items can run back to back.
// Reset: cursor goes home, counts return to 80 columns and 37 rows, and both
//   queues empty.
// Stall: when pop is held low, results collect in a two-entry result queue,
//   then the back end stops and the two-entry command queue fills, after
//   which full rises. No item is dropped.
// ----------------------------------------------------------------------------
module text_terminal_cursor_engine_unit
   import ttce_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic       req_func,
   input  logic [7:0] req_ch,
   input  logic [7:0] req_fore,
   input  logic [7:0] req_back,
   input  logic [6:0] req_col,
   input  logic [5:0] req_row,
   output logic       empty,
   input  logic       pop,
   output logic [1:0] rsp_action,
   output logic [6:0] rsp_cell_col,
   output logic [5:0] rsp_cell_row,
   output logic [7:0] rsp_glyph,
   output logic [7:0] rsp_fore_color,
   output logic [7:0] rsp_back_color,
   output logic [6:0] rsp_cursor_col_now,
   output logic [5:0] rsp_cursor_row_now,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_data
);

   geom_type geom_ff, geom_in;
   cmd_type  cmd_new, cmd_head;
   res_type  res_new, res_head;
   logic     cmd_empty, cmd_take;
   logic     res_full, res_push;

   assign csr_ready = 1'b1;

   always_comb begin
      geom_in = geom_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_COL_COUNT: geom_in.cols = limit_cols(csr_data);
            REG_ROW_COUNT: geom_in.rows = limit_rows(csr_data[6:0]);
            default:       geom_in = geom_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff.cols <= limit_cols(COL_COUNT_RST);
         geom_ff.rows <= limit_rows(ROW_COUNT_RST);
      end else begin
         geom_ff <= geom_in;
      end
   end

   ttce_front u_front (
      .func (req_func),
      .ch   (req_ch),
      .fore (req_fore),
      .back (req_back),
      .col  (req_col),
      .row  (req_row),
      .cmd  (cmd_new)
   );

   ttce_fifo #(
      .WIDTH ($bits(cmd_type))
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (cmd_new),
      .full    (full),
      .rd_en   (cmd_take),
      .rd_data (cmd_head),
      .empty   (cmd_empty)
   );

   ttce_back u_back (
      .clock     (clock),
      .reset     (reset),
      .geom      (geom_ff),
      .cmd_avail (~cmd_empty),
      .cmd       (cmd_head),
      .cmd_take  (cmd_take),
      .res_full  (res_full),
      .res_push  (res_push),
      .res       (res_new)
   );

   ttce_fifo #(
      .WIDTH ($bits(res_type))
   ) u_res_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_push),
      .wr_data (res_new),
      .full    (res_full),
      .rd_en   (pop),
      .rd_data (res_head),
      .empty   (empty)
   );

   assign rsp_action         = res_head.action;
   assign rsp_cell_col       = res_head.cell_col;
   assign rsp_cell_row       = res_head.cell_row;
   assign rsp_glyph          = res_head.glyph;
   assign rsp_fore_color     = res_head.fore_color;
   assign rsp_back_color     = res_head.back_color;
   assign rsp_cursor_col_now = res_head.cursor_col_now;
   assign rsp_cursor_row_now = res_head.cursor_row_now;

endmodule
